// ===== rtl/core/dsf_pkg.sv =====
// Shared types, constants and helpers of the damped spring force block.
`default_nettype none

package dsf_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;

  typedef logic signed [WORD_BITS-1:0] sword_t;
  typedef logic [WORD_BITS-1:0] uword_t;

  // square root: 2W-bit radicand, one root bit per stage
  localparam int SQ_W        = 2 * WORD_BITS;
  localparam int SQRT_STAGES = WORD_BITS;
  // |d| <= distance, so the quotient needs only FRAC_BITS+1 bits
  localparam int DIV_STAGES  = FRAC_BITS + 1;
  localparam int U_W         = FRAC_BITS + 2;
  localparam int PROD_W      = U_W + WORD_BITS;
  localparam int MUL_W       = 2 * WORD_BITS + 1;
  localparam int SAT_IN_W    = 2 * WORD_BITS + 2;

  localparam int QUEUE_DEPTH = 2;

  // back pipeline stage positions
  localparam int P_SQ       = 0;
  localparam int P_SUM      = P_SQ + 1;
  localparam int P_ROOT     = P_SUM + SQRT_STAGES;
  localparam int P_QUO      = P_ROOT + DIV_STAGES;
  localparam int P_U        = P_QUO + 1;
  localparam int P_M1       = P_U + 1;
  localparam int P_M2       = P_M1 + 1;
  localparam int P_M3       = P_M2 + 1;
  localparam int P_M4       = P_M3 + 1;
  localparam int P_M5       = P_M4 + 1;
  localparam int P_OUT      = P_M5 + 1;
  localparam int NUM_STAGES = P_OUT + 1;

  typedef enum logic [1:0] {
    CFG_ENABLED  = 2'd0,
    CFG_STRENGTH = 2'd1,
    CFG_DAMPING  = 2'd2,
    CFG_REST     = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    sword_t delta_pos_x;
    sword_t delta_pos_y;
    sword_t delta_pos_z;
    sword_t delta_vel_x;
    sword_t delta_vel_y;
    sword_t delta_vel_z;
    logic   free_a;
    logic   free_b;
  } in_word_t;

  typedef struct packed {
    sword_t force_a_x;
    sword_t force_a_y;
    sword_t force_a_z;
    sword_t force_b_x;
    sword_t force_b_y;
    sword_t force_b_z;
    logic   apply_a;
    logic   apply_b;
  } out_word_t;

  // classified item held in the queue
  typedef struct packed {
    uword_t [2:0] dmag;
    logic   [2:0] dneg;
    sword_t [2:0] vel;
    logic         apply_a;
    logic         apply_b;
    logic         zero;
  } item_t;

  function automatic sword_t sat_word(input logic signed [SAT_IN_W-1:0] v);
    logic [SAT_IN_W-WORD_BITS:0] top;
    top = v[SAT_IN_W-1:WORD_BITS-1];
    if ((&top) || !(|top)) begin
      return v[WORD_BITS-1:0];
    end else if (v[SAT_IN_W-1]) begin
      return {1'b1, {(WORD_BITS-1){1'b0}}};
    end else begin
      return {1'b0, {(WORD_BITS-1){1'b1}}};
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/damped_spring_force.sv =====
// Damped spring force top level: config registers, front end, queue, back pipeline.
//
// Usage: each input word describes one spring (position and velocity of end A minus
// end B, Q16.16, plus end-free flags). Each output word is the force on A, its
// negation for B, and the two apply flags. Both channels are valid/ready; an input
// word is taken when in_valid_i and in_ready_o are high at a clock edge.
// Config: cfg_we_i writes cfg_data_i to register cfg_idx_i (enabled, spring
// strength, damping gain, rest length); write only while no word is in flight.
// Throughput: one word per cycle unless the output stalls; the 32-stage square root
// and the three 17-stage dividers are fully pipelined, one result bit per stage.
// Stall: while a valid output word waits with out_ready_i low the whole back
// pipeline holds; the two-entry queue still absorbs input words, then in_ready_o drops.
// Reset (rst_ni low, async): enabled = 1, other registers 0, pipeline and queue
// emptied; no clearing pass is needed.
`default_nettype none

module damped_spring_force (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  dsf_pkg::uword_t     cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  dsf_pkg::in_word_t   in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output dsf_pkg::out_word_t  out_word_o
);
  import dsf_pkg::*;

  logic   enabled_q;
  sword_t strength_q, damping_q, rest_q;

  logic   push, full, q_valid, q_pop;
  item_t  push_item, q_item;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q  <= 1'b1;
      strength_q <= '0;
      damping_q  <= '0;
      rest_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ENABLED:  enabled_q  <= cfg_data_i[0];
        CFG_STRENGTH: strength_q <= cfg_data_i;
        CFG_DAMPING:  damping_q  <= cfg_data_i;
        CFG_REST:     rest_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // classify: magnitudes and signs of the offset, apply flags, disabled marker
  dsf_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .enabled_i  (enabled_q),
    .full_i     (full),
    .push_o     (push),
    .item_o     (push_item)
  );

  dsf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  // squares, sqrt, divide, then the force arithmetic and output register
  dsf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .strength_i  (strength_q),
    .damping_i   (damping_q),
    .rest_i      (rest_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

`ifndef SYNTH
  a_ready_low_means_queued : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> q_valid)
    else $error("input stalled with an empty queue");

  a_no_pop_while_stalled : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !q_pop)
    else $error("queue popped while the output is stalled");

  a_force_b_negates_a : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.force_b_x == -out_word_o.force_a_x)
                 || (out_word_o.force_b_x == {1'b0, {(WORD_BITS-1){1'b1}}}))
    else $error("force on B is not the negation of force on A");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/dsf_front.sv =====
// Front end: accepts input words and classifies them for the queue.
`default_nettype none

module dsf_front (
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  dsf_pkg::in_word_t in_word_i,
  input  logic             enabled_i,
  input  logic             full_i,
  output logic             push_o,
  output dsf_pkg::item_t   item_o
);
  import dsf_pkg::*;

  sword_t [2:0] dpos;

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;
  assign dpos       = {in_word_i.delta_pos_z, in_word_i.delta_pos_y, in_word_i.delta_pos_x};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      item_o.dneg[i] = dpos[i][WORD_BITS-1];
      item_o.dmag[i] = dpos[i][WORD_BITS-1] ? (~dpos[i] + uword_t'(1)) : dpos[i];
    end
    item_o.vel     = {in_word_i.delta_vel_z, in_word_i.delta_vel_y, in_word_i.delta_vel_x};
    item_o.apply_a = enabled_i && in_word_i.free_a;
    item_o.apply_b = enabled_i && in_word_i.free_b;
    item_o.zero    = !enabled_i;
  end

endmodule

`default_nettype wire

// ===== rtl/core/dsf_queue.sv =====
// Two-entry queue between the front end and the back pipeline.
`default_nettype none

module dsf_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  dsf_pkg::item_t item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output dsf_pkg::item_t item_o
);
  import dsf_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/dsf_sqrt.sv =====
// Pipelined integer square root, one root bit per stage.
`default_nettype none

module dsf_sqrt (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [dsf_pkg::SQ_W-1:0]   rad_i,
  output dsf_pkg::uword_t            root_o
);
  import dsf_pkg::*;

  localparam int REM_W = WORD_BITS + 2;

  logic [REM_W-1:0] rem_q [SQRT_STAGES];
  logic [REM_W-1:0] rem_d [SQRT_STAGES];
  uword_t           root_q [SQRT_STAGES];
  uword_t           root_d [SQRT_STAGES];
  logic [SQ_W-1:0]  rad_q [SQRT_STAGES];
  logic [SQ_W-1:0]  rad_d [SQRT_STAGES];

  always_comb begin
    logic [REM_W-1:0] ri;
    uword_t           qi;
    logic [SQ_W-1:0]  xi;
    logic [REM_W+1:0] r2, trial;
    logic             ge;
    for (int j = 0; j < SQRT_STAGES; j++) begin
      ri    = (j == 0) ? '0 : rem_q[(j == 0) ? 0 : j-1];
      qi    = (j == 0) ? '0 : root_q[(j == 0) ? 0 : j-1];
      xi    = (j == 0) ? rad_i : rad_q[(j == 0) ? 0 : j-1];
      r2    = {ri, xi[SQ_W-1 -: 2]};
      trial = (REM_W+2)'({qi, 2'b01});
      ge    = (r2 >= trial);
      rem_d[j]  = ge ? REM_W'(r2 - trial) : REM_W'(r2);
      root_d[j] = {qi[WORD_BITS-2:0], ge};
      rad_d[j]  = xi << 2;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < SQRT_STAGES; j++) begin
        rem_q[j]  <= rem_d[j];
        root_q[j] <= root_d[j];
        rad_q[j]  <= rad_d[j];
      end
    end
  end

  assign root_o = root_q[SQRT_STAGES-1];

endmodule

`default_nettype wire

// ===== rtl/core/dsf_div.sv =====
// Pipelined restoring divider for one direction component: (mag << F) / den.
`default_nettype none

module dsf_div (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  dsf_pkg::uword_t                 mag_i,
  input  dsf_pkg::uword_t                 den_i,
  output logic [dsf_pkg::DIV_STAGES-1:0]  quo_o,
  output dsf_pkg::uword_t                 den_o
);
  import dsf_pkg::*;

  localparam int NUM_W = WORD_BITS + FRAC_BITS;

  uword_t                rem_q [DIV_STAGES];
  uword_t                rem_d [DIV_STAGES];
  logic [DIV_STAGES-1:0] low_q [DIV_STAGES];
  logic [DIV_STAGES-1:0] low_d [DIV_STAGES];
  logic [DIV_STAGES-1:0] quo_q [DIV_STAGES];
  logic [DIV_STAGES-1:0] quo_d [DIV_STAGES];
  uword_t                den_q [DIV_STAGES];
  uword_t                den_d [DIV_STAGES];
  logic [NUM_W-1:0]      num;

  assign num = {mag_i, FRAC_BITS'(0)};

  // the top bits of the dividend are already below the divisor
  always_comb begin
    uword_t                ri, di;
    logic [DIV_STAGES-1:0] li, qi;
    logic [WORD_BITS:0]    r2;
    logic                  ge;
    for (int k = 0; k < DIV_STAGES; k++) begin
      ri = (k == 0) ? WORD_BITS'(num[NUM_W-1:DIV_STAGES]) : rem_q[(k == 0) ? 0 : k-1];
      li = (k == 0) ? num[DIV_STAGES-1:0] : low_q[(k == 0) ? 0 : k-1];
      qi = (k == 0) ? '0 : quo_q[(k == 0) ? 0 : k-1];
      di = (k == 0) ? den_i : den_q[(k == 0) ? 0 : k-1];
      r2 = {ri, li[DIV_STAGES-1]};
      ge = (r2 >= {1'b0, di});
      rem_d[k] = ge ? WORD_BITS'(r2 - {1'b0, di}) : WORD_BITS'(r2);
      low_d[k] = li << 1;
      quo_d[k] = {qi[DIV_STAGES-2:0], ge};
      den_d[k] = di;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        rem_q[k] <= rem_d[k];
        low_q[k] <= low_d[k];
        quo_q[k] <= quo_d[k];
        den_q[k] <= den_d[k];
      end
    end
  end

  assign quo_o = quo_q[DIV_STAGES-1];
  assign den_o = den_q[DIV_STAGES-1];

endmodule

`default_nettype wire

// ===== rtl/core/dsf_back.sv =====
// Back pipeline: distance, direction, Hooke and damping forces, output register.
`default_nettype none

module dsf_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  dsf_pkg::item_t      q_item_i,
  output logic                q_pop_o,
  input  dsf_pkg::sword_t     strength_i,
  input  dsf_pkg::sword_t     damping_i,
  input  dsf_pkg::sword_t     rest_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output dsf_pkg::out_word_t  out_word_o
);
  import dsf_pkg::*;

  localparam int U_TAPS = P_M5 - P_U;

  logic                     adv;
  logic [NUM_STAGES-1:0]    vld_q;
  item_t                    side_q [P_M5+1];
  logic [SQ_W-1:0]          sq_q [3];
  logic [SQ_W-1:0]          sum_q;
  uword_t                   root;
  logic [DIV_STAGES-1:0]    quo [3];
  uword_t                   dist_div;
  uword_t                   dist_q;
  logic signed [U_W-1:0]    u_q [U_TAPS][3];
  logic signed [PROD_W-1:0] uv_q [3];
  sword_t                   stretch_q, dot_q, fs_q, r_q;
  logic signed [MUL_W-1:0]  fsp_q, fdp_q;
  logic signed [PROD_W-1:0] fap_q [3];
  out_word_t                out_q, out_d;

  logic signed [U_W-1:0]    u_d [3];
  logic signed [PROD_W+1:0] uv_sum;
  logic signed [WORD_BITS:0] nstr, ndamp;
  sword_t                   fd;
  sword_t [2:0]             fa, fb;

  assign adv         = !vld_q[NUM_STAGES-1] || out_ready_i;
  assign q_pop_o     = adv && q_valid_i;
  assign out_valid_o = vld_q[NUM_STAGES-1];
  assign out_word_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NUM_STAGES-2:0], q_valid_i};
    end
  end

  dsf_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (adv),
    .rad_i  (sum_q),
    .root_o (root)
  );

  for (genvar g = 0; g < 3; g++) begin : g_div
    if (g == 0) begin : g_lead
      dsf_div u_div (
        .clk_i (clk_i),
        .en_i  (adv),
        .mag_i (side_q[P_ROOT].dmag[g]),
        .den_i (root),
        .quo_o (quo[g]),
        .den_o (dist_div)
      );
    end else begin : g_rest
      dsf_div u_div (
        .clk_i (clk_i),
        .en_i  (adv),
        .mag_i (side_q[P_ROOT].dmag[g]),
        .den_i (root),
        .quo_o (quo[g]),
        .den_o ()
      );
    end
  end

  always_comb begin
    // signed direction, zero at zero distance
    for (int i = 0; i < 3; i++) begin
      if (dist_div == '0) begin
        u_d[i] = '0;
      end else if (side_q[P_QUO].dneg[i]) begin
        u_d[i] = -$signed({1'b0, quo[i]});
      end else begin
        u_d[i] = $signed({1'b0, quo[i]});
      end
    end
    uv_sum = (PROD_W+2)'(uv_q[0]) + (PROD_W+2)'(uv_q[1]) + (PROD_W+2)'(uv_q[2]);
    nstr   = -((WORD_BITS+1)'(stretch_q));
    ndamp  = -((WORD_BITS+1)'(damping_i));
    fd     = sat_word(SAT_IN_W'(fdp_q >>> FRAC_BITS));
    for (int i = 0; i < 3; i++) begin
      fa[i] = sat_word(SAT_IN_W'(fap_q[i] >>> FRAC_BITS));
      fb[i] = sat_word(-SAT_IN_W'(fa[i]));
    end
    if (side_q[P_M5].zero) begin
      out_d = '0;
    end else begin
      out_d.force_a_x = fa[0];
      out_d.force_a_y = fa[1];
      out_d.force_a_z = fa[2];
      out_d.force_b_x = fb[0];
      out_d.force_b_y = fb[1];
      out_d.force_b_z = fb[2];
      out_d.apply_a   = side_q[P_M5].apply_a;
      out_d.apply_b   = side_q[P_M5].apply_b;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0] <= q_item_i;
      for (int k = 1; k <= P_M5; k++) begin
        side_q[k] <= side_q[k-1];
      end
      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= SQ_W'(q_item_i.dmag[i]) * SQ_W'(q_item_i.dmag[i]);
      end
      sum_q  <= sq_q[0] + sq_q[1] + sq_q[2];
      dist_q <= dist_div;
      for (int i = 0; i < 3; i++) begin
        u_q[0][i] <= u_d[i];
        uv_q[i]   <= u_q[0][i] * side_q[P_U].vel[i];
        fap_q[i]  <= u_q[U_TAPS-1][i] * r_q;
      end
      for (int k = 1; k < U_TAPS; k++) begin
        u_q[k] <= u_q[k-1];
      end
      stretch_q <= sat_word(SAT_IN_W'($signed({2'b00, dist_q})) - SAT_IN_W'(rest_i));
      dot_q     <= sat_word(SAT_IN_W'(uv_sum >>> FRAC_BITS));
      fsp_q     <= nstr * strength_i;
      fs_q      <= sat_word(SAT_IN_W'(fsp_q >>> FRAC_BITS));
      fdp_q     <= ndamp * dot_q;
      r_q       <= sat_word(SAT_IN_W'(fs_q) + SAT_IN_W'(fd));
      out_q     <= out_d;
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/damped_spring_force_test.sv =====
// Testbench for the damped spring force block: predicted forces checked against each output word.
`timescale 1ns / 100ps
`default_nettype none

module damped_spring_force_test;
  import dsf_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int LATENCY        = 58;
  localparam longint S64_MAX    = 64'sh7fff_ffff_ffff_ffff;
  localparam longint W_MAX      = 64'sh0000_0000_7fff_ffff;
  localparam longint W_MIN      = -64'sh0000_0000_8000_0000;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = CFG_ENABLED;
  uword_t     cfg_data_i = '0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  in_word_t   in_word_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  out_word_t  out_word_o;

  damped_spring_force uut (.*);

  // 20 ns period
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // shadow copy of the config registers
  logic   sh_enabled;
  longint sh_strength, sh_damping, sh_rest;

  out_word_t expected_forces[$];
  int  mismatch_cnt, words_sent, words_checked, idle_cycles;
  int  send_idle_pct, recv_stall_pct;
  bit  hold_off;

  // ---------------- predictor ----------------
  function automatic longint mul_sat(longint a, longint b);
    longint unsigned ma, mb;
    bit neg;
    ma = a < 0 ? -a : a;
    mb = b < 0 ? -b : b;
    neg = (a < 0) != (b < 0);
    if (mb != 0 && ma > longint'(S64_MAX) / mb) return neg ? -S64_MAX : S64_MAX;
    return neg ? -longint'(ma * mb) : longint'(ma * mb);
  endfunction

  function automatic longint add_sat(longint a, longint b);
    if (b > 0 && a > S64_MAX - b) return S64_MAX;
    if (b < 0 && a < -S64_MAX - b) return -S64_MAX;
    return a + b;
  endfunction

  // floor division by 2^FRAC_BITS
  function automatic longint floor_frac(longint v);
    return v >>> FRAC_BITS;
  endfunction

  function automatic longint clamp_word(longint v);
    if (v > W_MAX) return W_MAX;
    if (v < W_MIN) return W_MIN;
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic out_word_t spring_force(in_word_t w);
    out_word_t r;
    longint d[3], v[3], u[3], fa;
    longint unsigned sum, m;
    longint span, stretch, fs, dot, fd, tot;
    r = '0;
    if (!sh_enabled) return r;
    d[0] = w.delta_pos_x; d[1] = w.delta_pos_y; d[2] = w.delta_pos_z;
    v[0] = w.delta_vel_x; v[1] = w.delta_vel_y; v[2] = w.delta_vel_z;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      m = d[i] < 0 ? -d[i] : d[i];
      sum += m * m;  // at most 3 * 2^62, fits
    end
    span = int_sqrt(sum);
    for (int i = 0; i < 3; i++)
      u[i] = span == 0 ? 0 : mul_sat(d[i], 64'sd1 << FRAC_BITS) / span;
    stretch = clamp_word(span - sh_rest);
    fs = clamp_word(floor_frac(mul_sat(-stretch, sh_strength)));
    dot = clamp_word(floor_frac(add_sat(add_sat(mul_sat(u[0], v[0]), mul_sat(u[1], v[1])),
                                        mul_sat(u[2], v[2]))));
    fd = clamp_word(floor_frac(mul_sat(-sh_damping, dot)));
    tot = clamp_word(fs + fd);
    fa = clamp_word(floor_frac(mul_sat(u[0], tot)));
    r.force_a_x = fa; r.force_b_x = clamp_word(-fa);
    fa = clamp_word(floor_frac(mul_sat(u[1], tot)));
    r.force_a_y = fa; r.force_b_y = clamp_word(-fa);
    fa = clamp_word(floor_frac(mul_sat(u[2], tot)));
    r.force_a_z = fa; r.force_b_z = clamp_word(-fa);
    r.apply_a = w.free_a;
    r.apply_b = w.free_b;
    return r;
  endfunction

  // ---------------- result checker ----------------
  always @(posedge clk_i) begin
    out_word_t exp_w;
    if (out_valid_o && out_ready_i) begin
      words_checked++;
      if (expected_forces.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("ERROR: unexpected output word %h", out_word_o);
      end else begin
        exp_w = expected_forces.pop_front();
        if (out_word_o !== exp_w) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display({"ERROR: word %0d exp fa=%0d,%0d,%0d fb=%0d,%0d,%0d ap=%b%b",
                      " got fa=%0d,%0d,%0d fb=%0d,%0d,%0d ap=%b%b"},
              words_checked, exp_w.force_a_x, exp_w.force_a_y, exp_w.force_a_z,
              exp_w.force_b_x, exp_w.force_b_y, exp_w.force_b_z, exp_w.apply_a, exp_w.apply_b,
              out_word_o.force_a_x, out_word_o.force_a_y, out_word_o.force_a_z,
              out_word_o.force_b_x, out_word_o.force_b_y, out_word_o.force_b_z,
              out_word_o.apply_a, out_word_o.apply_b);
        end
      end
    end
  end

  // receiver: random stall, or a long hold-off when asked
  always @(posedge clk_i) begin
    out_ready_i <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog: cycles with no handshake on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", idle_cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------- stimulus helpers ----------------
  // valid stays high after an accept; it drops only on an idle cycle or at drain
  task automatic send_word(in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_forces.push_back(spring_force(w));
    words_sent++;
  endtask

  task automatic wait_drain();
    in_valid_i <= 1'b0;
    while (expected_forces.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 5) @(posedge clk_i);
  endtask

  // config write; block must be idle
  task automatic write_reg(cfg_idx_e idx, longint val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= uword_t'(val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_ENABLED:  sh_enabled  = val[0];
      CFG_STRENGTH: sh_strength = sword_t'(val);
      CFG_DAMPING:  sh_damping  = sword_t'(val);
      CFG_REST:     sh_rest     = sword_t'(val);
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_spring(bit en, longint k, longint c, longint l);
    write_reg(CFG_ENABLED, en);
    write_reg(CFG_STRENGTH, k);
    write_reg(CFG_DAMPING, c);
    write_reg(CFG_REST, l);
  endtask

  // mostly modest vectors, some full-range words
  function automatic sword_t rand_field();
    case ($urandom_range(3))
      0:       return $urandom;
      1:       return $signed($urandom_range(32'h0004_0000)) - 32'sh0002_0000;
      2:       return $signed($urandom_range(32'h0100_0000)) - 32'sh0080_0000;
      default: return $urandom_range(1) ? 32'sh7fff_ffff : 32'sh8000_0000;
    endcase
  endfunction

  function automatic in_word_t rand_word();
    in_word_t w;
    w.delta_pos_x = rand_field(); w.delta_pos_y = rand_field();
    w.delta_pos_z = rand_field(); w.delta_vel_x = rand_field();
    w.delta_vel_y = rand_field(); w.delta_vel_z = rand_field();
    if ($urandom_range(9) == 0) begin
      w.delta_pos_x = 0; w.delta_pos_y = 0; w.delta_pos_z = 0;  // coincident ends
    end
    w.free_a = $urandom_range(1);
    w.free_b = $urandom_range(1);
    return w;
  endfunction

  function automatic longint rand_param();
    case ($urandom_range(2))
      0:       return sword_t'($urandom);
      1:       return longint'($urandom_range(32'h0008_0000)) - 64'sh4_0000;
      default: return longint'($urandom_range(32'h0001_0000));
    endcase
  endfunction

  // ---------------- tests ----------------
  task automatic test_directed();
    in_word_t w;
    sword_t ext[4] = '{32'sh7fff_ffff, 32'sh8000_0000, 32'sh0, 32'sh0001_0000};
    set_spring(1'b1, 32'sh0002_0000, 32'sh0000_8000, 32'sh0001_0000);
    // coincident ends: zero direction, zero force
    w = '0; w.free_a = 1; w.free_b = 1; w.delta_vel_x = 32'sh0010_0000;
    send_word(w);
    // separation of 3.0 along each axis, flag combinations
    for (int a = 0; a < 3; a++) begin
      w = '0;
      w.free_a = a[0]; w.free_b = a[1];
      w.delta_pos_x = a == 0 ? 32'sh0003_0000 : 0;
      w.delta_pos_y = a == 1 ? -32'sh0003_0000 : 0;
      w.delta_pos_z = a == 2 ? 32'sh0003_0000 : 0;
      w.delta_vel_x = 32'sh0001_0000; w.delta_vel_y = -32'sh0002_0000;
      send_word(w);
    end
    // field extremes: max and min in every field
    for (int i = 0; i < 4; i++) begin
      w.delta_pos_x = ext[i]; w.delta_pos_y = ext[(i+1)%4]; w.delta_pos_z = ext[(i+2)%4];
      w.delta_vel_x = ext[(i+3)%4]; w.delta_vel_y = ext[i]; w.delta_vel_z = ext[(i+1)%4];
      w.free_a = i[0]; w.free_b = ~i[0];
      send_word(w);
    end
    wait_drain();
    // extreme parameters: force saturation, negation of most negative force
    set_spring(1'b1, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000);
    for (int i = 0; i < 4; i++) send_word(rand_word());
    w = '0; w.delta_pos_x = 32'sh7fff_ffff; w.free_a = 1; send_word(w);
    w.delta_pos_x = 32'sh8000_0000; w.delta_vel_x = 32'sh7fff_ffff; send_word(w);
    wait_drain();
    set_spring(1'b1, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff);
    for (int i = 0; i < 4; i++) send_word(rand_word());
    wait_drain();
    // disabled spring: everything zero
    write_reg(CFG_ENABLED, 0);
    w = '1; send_word(w);
    for (int i = 0; i < 3; i++) send_word(rand_word());
    wait_drain();
  endtask

  task automatic test_random_phase(int n, int idle_pct, int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    set_spring($urandom_range(7) != 0, rand_param(), rand_param(), rand_param());
    for (int i = 0; i < n; i++) send_word(rand_word());
    wait_drain();
  endtask

  // receiver holds off long enough for the pipe and queue to fill
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_spring(1'b1, 32'sh0001_8000, 32'sh0000_4000, 32'sh0002_0000);
    fork
      begin
        hold_off = 1'b1;
        repeat (200) @(posedge clk_i);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 80; i++) send_word(rand_word());
    join
    wait_drain();
  endtask

  initial begin
    sh_enabled = 1'b1; sh_strength = 0; sh_damping = 0; sh_rest = 0;
    mismatch_cnt = 0; words_sent = 0; words_checked = 0; idle_cycles = 0;
    send_idle_pct = 0; recv_stall_pct = 0; hold_off = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_phase(90, 0, 0);
    test_random_phase(90, 76, 0);
    test_random_phase(90, 0, 76);
    test_random_phase(90, 38, 38);
    test_backpressure();

    $display("Covered %0d spring words (%0d checked): extremes, coincident ends, disabled,",
             words_sent, words_checked);
    $display("saturating parameters, random idle/stall phases and a long output hold-off.");
    if (mismatch_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", mismatch_cnt);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
